### rtl/core/dcsc_pkg.sv
// shared types and constants for the dual channel serial controller
`timescale 1ns / 1ps
`default_nettype none
package dcsc_pkg;

  localparam int unsigned RxDepth = 64;
  localparam int unsigned TxDepth = 64;
  localparam int unsigned RxAw = $clog2(RxDepth);
  localparam int unsigned TxAw = $clog2(TxDepth);
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    ACT_CTRL_RD  = 3'd0,
    ACT_CTRL_WR  = 3'd1,
    ACT_DATA_RD  = 3'd2,
    ACT_DATA_WR  = 3'd3,
    ACT_LINE_IN  = 3'd4,
    ACT_TX_TAKE  = 3'd5,
    ACT_NONE_6   = 3'd6,
    ACT_NONE_7   = 3'd7
  } action_e;

  // classified beat passed from front to back
  typedef struct packed {
    action_e    act;
    logic       ch;
    logic [7:0] val;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       byte_valid;
    logic       fault;
    logic       irq_line;
  } res_t;

  localparam logic [7:0] Rr0Base   = 8'h6c;
  localparam logic [7:0] Wr3Mask   = 8'hde;
  localparam logic [7:0] Wr3Val    = 8'hc0;
  localparam logic [7:0] Wr5Mask   = 8'hf5;
  localparam logic [7:0] Wr5Val    = 8'h60;
  localparam logic [7:0] Wr9Mask   = 8'h35;
  localparam logic [7:0] Wr11Mask  = 8'h78;
  localparam logic [7:0] Wr11Val   = 8'h50;
  localparam logic [7:0] Wr14Mask  = 8'h1c;
  localparam logic [7:0] Wr1IntRx  = 8'h10;
  localparam logic [7:0] Wr1IntRxT = 8'h12;
  localparam logic [7:0] DataMask  = 8'h7f;

  localparam logic [2:0] CmdRstTx  = 3'd5;
  localparam logic [2:0] CmdRstHi  = 3'd7;

endpackage
`default_nettype wire

### rtl/core/dcsc_front.sv
// front end: input queue that takes beats and holds them for the back end
`timescale 1ns / 1ps
`default_nettype none
module dcsc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire logic [2:0]      action_i,
  input  wire logic            port_i,
  input  wire logic [7:0]      value_i,
  output logic                 cmd_valid_o,
  output dcsc_pkg::cmd_t       cmd_o,
  input  wire logic            cmd_take_i
);
  import dcsc_pkg::*;

  cmd_t       buf_q [QDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push_ok;

  assign full_o      = (cnt_q == 2'(QDepth));
  assign push_ok     = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_q];

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      buf_q[wr_q] <= '{act: action_e'(action_i), ch: port_i, val: value_i};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_ok) wr_q <= ~wr_q;
      if (cmd_take_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_ok) - 2'(cmd_take_i);
    end
  end

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("front queue overfilled");
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_i |-> cmd_valid_o) else $error("take from empty front queue");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !cmd_take_i) |=> full_o) else $error("full dropped without take");
endmodule
`default_nettype wire

### rtl/core/dcsc_back.sv
// back end: register file, fifos and interrupt state, one beat at a time
`timescale 1ns / 1ps
`default_nettype none
module dcsc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire dcsc_pkg::cmd_t  cmd_i,
  output logic                 cmd_take_o,
  output logic                 res_valid_o,
  output dcsc_pkg::res_t       res_o,
  input  wire logic            res_take_i
);
  import dcsc_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e          state_q;
  cmd_t            c_q;
  res_t            res_q;
  logic            res_vld_q;
  logic [7:0]      wr_q [2][16];
  logic [3:0]      ptr_q [2];
  logic [1:0]      pmode_q;
  logic [RxAw-1:0] rxr_q [2], rxw_q [2];
  logic [TxAw-1:0] txr_q [2], txw_q [2];
  logic [1:0]      rxp_q, txp_q;
  logic [7:0]      rxmem_q [2*RxDepth];
  logic [6:0]      txmem_q [2*TxDepth];
  logic [7:0]      rxrd_q;
  logic [6:0]      txrd_q;

  // decode of the held beat
  logic            ch;
  logic [7:0]      v;
  logic [RxAw-1:0] rxnx, rxrdnx;
  logic [TxAw-1:0] txnx, txrdnx;
  logic            rx_empty, tx_empty, rx_full, tx_full, men;
  logic [1:0]      rxmode;
  logic [3:0]      reg_sel;

  always_comb begin
    ch       = c_q.ch;
    v        = c_q.val;
    rxnx     = RxAw'(rxw_q[ch] + 1'b1);
    rxrdnx   = RxAw'(rxr_q[ch] + 1'b1);
    txnx     = TxAw'(txw_q[ch] + 1'b1);
    txrdnx   = TxAw'(txr_q[ch] + 1'b1);
    rx_empty = (rxr_q[ch] == rxw_q[ch]);
    tx_empty = (txr_q[ch] == txw_q[ch]);
    rx_full  = (rxnx == rxr_q[ch]);
    tx_full  = (txnx == txr_q[ch]);
    men      = wr_q[0][9][3];
    rxmode   = wr_q[ch][1][4:3];
    reg_sel  = ptr_q[ch];
  end

  // a beat is taken only when the result register is free by the time it executes
  assign cmd_take_o  = (state_q == ST_IDLE) && cmd_valid_i && (!res_vld_q || res_take_i);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // fifo memory reads, registered in the cycle before execution
  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      rxrd_q <= rxmem_q[{cmd_i.ch, rxr_q[cmd_i.ch]}];
      txrd_q <= txmem_q[{cmd_i.ch, txr_q[cmd_i.ch]}];
      c_q    <= cmd_i;
    end
  end

  // fifo memory writes
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC && !rx_full &&
        ((c_q.act == ACT_LINE_IN && v != 8'd0) ||
         (c_q.act == ACT_DATA_WR && wr_q[ch][14][4]))) begin
      rxmem_q[{ch, rxw_q[ch]}] <= (c_q.act == ACT_DATA_WR) ? (v & DataMask) : v;
    end
    if (state_q == ST_EXEC && c_q.act == ACT_DATA_WR && !wr_q[ch][14][4] && !tx_full) begin
      txmem_q[{ch, txw_q[ch]}] <= v[6:0];
    end
  end

  // execution and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] r;
    logic       f, bv, rxreq, wen;
    logic [3:0] wreg;
    logic [1:0] rxp, txp;
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 16; j++) wr_q[i][j] <= 8'd0;
        ptr_q[i] <= 4'd0;
        rxr_q[i] <= '0; rxw_q[i] <= '0; txr_q[i] <= '0; txw_q[i] <= '0;
      end
      pmode_q <= 2'b0; rxp_q <= 2'b0; txp_q <= 2'b0;
      res_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (res_take_i) res_vld_q <= 1'b0;
          if (cmd_take_o) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          r = 8'd0; f = 1'b0; bv = 1'b0; rxreq = 1'b0; wen = 1'b0; wreg = reg_sel;
          rxp = rxp_q; txp = txp_q;
          unique case (c_q.act)
            ACT_CTRL_RD: begin
              pmode_q[ch] <= 1'b0;
              ptr_q[ch]   <= 4'd0;
              unique case (reg_sel)
                4'd0: r = Rr0Base | {7'd0, !rx_empty};
                4'd1: r = 8'h01;
                4'd2: if (!ch) r = wr_q[0][2]; else f = 1'b1;
                4'd3: if (!ch) r = {2'b0, rxp[0], txp[0], 1'b0, rxp[1], txp[1], 1'b0};
                4'd9: r = wr_q[0][9];
                4'd10, 4'd12, 4'd13, 4'd14, 4'd15: r = wr_q[ch][reg_sel];
                default: f = 1'b1;
              endcase
            end
            ACT_CTRL_WR: begin
              if (!pmode_q[ch]) begin
                if (v[7:4] == 4'd0) begin
                  ptr_q[ch] <= v[3:0]; pmode_q[ch] <= 1'b1; wreg = 4'd0;
                end
              end else begin
                ptr_q[ch] <= 4'd0; pmode_q[ch] <= 1'b0;
              end
              wen = 1'b1;
              unique case (wreg)
                4'd0: begin
                  wen = 1'b0;
                  if (v[5:3] == CmdRstTx) txp[ch] = 1'b0;
                  else if (v[5:3] == CmdRstHi) begin
                    if (rxp[ch]) rxp[ch] = 1'b0; else txp[ch] = 1'b0;
                  end else if (v[5:3] > 3'd2) f = 1'b1;
                  if (v[7:6] != 2'b0) f = 1'b1;
                end
                4'd1: f = (v != 8'd0 && v != Wr1IntRx && v != Wr1IntRxT);
                4'd2, 4'd12, 4'd13: f = 1'b0;
                4'd3: f = ((v & Wr3Mask) != Wr3Val);
                4'd4: f = (v[5:4] != 2'b0);
                4'd5: f = ((v & Wr5Mask) != Wr5Val);
                4'd6, 4'd7, 4'd10: f = (v != 8'd0);
                4'd9: begin
                  wen = 1'b0;
                  f = ((v & Wr9Mask) != 8'd0);
                  if (wr_q[0][9][3] && !v[3]) begin rxp = 2'b0; txp = 2'b0; end
                  wr_q[0][9] <= v;
                end
                4'd11: f = ((v & Wr11Mask) != Wr11Val);
                4'd14: f = (v[7:5] != 3'd0 && v[7:5] != 3'd4) || ((v & Wr14Mask) != 8'd0);
                4'd15: f = men && (v != 8'd0);
                default: begin f = 1'b1; wen = 1'b0; end
              endcase
              if (wen) wr_q[ch][wreg] <= v;
            end
            ACT_DATA_RD: begin
              if (!rx_empty) begin
                r = rxrd_q;
                rxr_q[ch] <= rxrdnx;
                if (rxmode == 2'd1 || (rxmode == 2'd2 && rxrdnx == rxw_q[ch]))
                  rxp[ch] = 1'b0;
              end
            end
            ACT_DATA_WR: begin
              if (wr_q[ch][14][4]) begin
                rxreq = 1'b1; f = rx_full;
              end else begin
                f = tx_full;
                if (!tx_full) txw_q[ch] <= txnx;
              end
            end
            ACT_LINE_IN: begin
              if (v != 8'd0) begin rxreq = 1'b1; f = rx_full; end
            end
            ACT_TX_TAKE: begin
              if (!tx_empty) begin
                r = {1'b0, txrd_q}; bv = 1'b1;
                txr_q[ch] <= txrdnx;
                if (men && wr_q[ch][1][1]) txp[ch] = 1'b1;
              end
            end
            default: ;
          endcase
          if (rxreq) begin
            if (!rx_full) rxw_q[ch] <= rxnx;
            if (men && (rxmode == 2'd1 || rxmode == 2'd2)) rxp[ch] = 1'b1;
          end
          rxp_q <= rxp; txp_q <= txp;
          res_q <= '{read_data: r, byte_valid: bv, fault: f,
                     irq_line: (|rxp) | (|txp)};
          res_vld_q <= 1'b1;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |=> state_q == ST_EXEC) else $error("beat not executed");
  a_exec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> res_valid_o) else $error("no result after execute");
  a_exec_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> !res_valid_o) else $error("result register busy on execute");
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_take_i) |=> $stable(res_q)) else $error("result moved");
  a_bv_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && c_q.act != ACT_TX_TAKE) |=> !res_q.byte_valid)
    else $error("byte_valid on non tx take");
endmodule
`default_nettype wire

### rtl/core/dual_channel_serial_controller_regs.sv
// top level of the dual channel serial controller
// Usage: bus accesses and line events enter as beats through a queue port
// (push / full) with fields action_i, port_i and value_i. Each beat gives
// exactly one result beat on the output queue port (empty / pop) with
// read_data_o, byte_valid_o, fault_o and irq_line_o.
// A two-entry input queue decouples the front from the back end. The back
// end takes a queued beat when it is idle and its result register is free
// or being popped, reads the fifo memories in that cycle and executes in
// the next, loading the result register, from which the result can then be
// popped. The back end takes no new beat while it is executing one.
// A result that is not popped stays in the result register and the back
// end takes no further beat; the input queue still takes up to two beats,
// then raises full.
// Reset clears all write registers, pointers, fifo indices and pending
// interrupt bits; fifo contents are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none
module dual_channel_serial_controller_regs (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] action_i,
  input  wire logic       port_i,
  input  wire logic [7:0] value_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      read_data_o,
  output logic            byte_valid_o,
  output logic            fault_o,
  output logic            irq_line_o
);
  import dcsc_pkg::*;

  cmd_t cmd;
  res_t res;
  logic cmd_valid, cmd_take, res_valid;

  // front end queue
  dcsc_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .action_i, .port_i, .value_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  // back end execution
  dcsc_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .res_valid_o(res_valid), .res_o(res), .res_take_i(pop && res_valid)
  );

  assign empty        = !res_valid;
  assign read_data_o  = res.read_data;
  assign byte_valid_o = res.byte_valid;
  assign fault_o      = res.fault;
  assign irq_line_o   = res.irq_line;
endmodule
`default_nettype wire
